// ===== sv/frame_timestamp_history_ring_top_assert.svh =====
// assertion macros used by the checker file
`ifndef FRAME_TIMESTAMP_HISTORY_RING_TOP_ASSERT_SVH
`define FRAME_TIMESTAMP_HISTORY_RING_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FTSHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FTSHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ftshr_pkg.sv =====
package ftshr_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_CAPTURE = 2'd0,
        KIND_DISCARD = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

    // default ring depth
    localparam int RING_DEPTH_DEF = 32;

    // query frame that selects the newest capture
    localparam logic [15:0] LATEST_FRAME = 16'hFFFF;

endpackage

// ===== sv/frame_timestamp_history_ring_top.sv =====
// frame timestamp history ring
// requests are taken on start while busy is low; kind selects capture,
// discard, query or counter clear, with the other fields as payload
// capture, discard and clear complete in the accepting cycle and leave
// busy low, so they may follow one another in every cycle
// a query raises busy and walks both rings newest first, each entry
// passing a read state (registered memory read), then a compare
// state; both rings are walked side by side, and the query ends once
// both walks are done (a walk ends at its first match or after
// min(entries, RING_DEPTH) entries)
// the result is shown for exactly one cycle with o_valid; the receiver
// cannot stall it, and busy is low again in that cycle
// reset clears the three counters and the ring pointers; ring contents
// are not cleared, and only entries written since the last clear or
// reset are ever searched
module frame_timestamp_history_ring_top #(
    parameter int RING_DEPTH = ftshr_pkg::RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_frame_number,
    input  logic [31:0] i_capture_clock,
    input  logic [7:0]  i_discard_mask,
    output logic        o_valid,
    output logic [15:0] o_requested_frame,
    output logic        o_found,
    output logic [15:0] o_match_frame,
    output logic [31:0] o_match_clock,
    output logic [31:0] o_match_sequence,
    output logic [31:0] o_capture_total,
    output logic [31:0] o_discard_total,
    output logic [31:0] o_masked_discard_total,
    output logic        o_discard_hit,
    output logic [7:0]  o_discard_hit_mask
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

    typedef struct packed {
        logic [15:0] frame;
        logic [31:0] clock;
        logic [31:0] sequence_cnt;
    } t_cap_entry;

    typedef struct packed {
        logic [15:0] frame;
        logic [7:0]  mask;
    } t_dis_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } t_state;

    // ring memories
    t_cap_entry cap_mem [RING_DEPTH];
    t_dis_entry dis_mem [RING_DEPTH];

    t_state        r_state;
    logic [31:0]   r_cap_cnt;
    logic [31:0]   r_dis_cnt;
    logic [31:0]   r_mdis_cnt;
    logic [PW-1:0] r_cap_ptr;
    logic [PW-1:0] r_dis_ptr;
    logic [PW-1:0] r_cap_addr;
    logic [PW-1:0] r_dis_addr;
    logic [SW-1:0] r_cap_left;
    logic [SW-1:0] r_dis_left;
    logic          r_cap_done;
    logic          r_dis_done;
    logic          r_valid;
    logic [15:0]   r_qframe;
    logic          r_found;
    t_cap_entry    r_match;
    logic          r_dhit;
    logic [7:0]    r_dmask;
    t_cap_entry    r_cap_rd;
    t_dis_entry    r_dis_rd;

    logic              accept;
    ftshr_pkg::t_kind  kind;
    logic              cap_wr;
    logic              dis_wr;
    t_cap_entry        cap_wdata;
    t_dis_entry        dis_wdata;
    logic [SW-1:0]     cap_span;
    logic [SW-1:0]     dis_span;
    logic              cap_hit;
    logic              dis_hit;
    logic              cap_done_n;
    logic              dis_done_n;

    assign kind   = ftshr_pkg::t_kind'(i_kind);
    assign accept = start && (r_state == ST_IDLE);
    assign cap_wr = accept && (kind == ftshr_pkg::KIND_CAPTURE);
    assign dis_wr = accept && (kind == ftshr_pkg::KIND_DISCARD);

    // write data for new ring entries
    assign cap_wdata = '{frame: i_frame_number, clock: i_capture_clock,
                         sequence_cnt: r_cap_cnt + 32'd1};
    assign dis_wdata = '{frame: i_frame_number, mask: i_discard_mask};

    // searched span is the smaller of counter and depth
    assign cap_span = (r_cap_cnt < 32'(RING_DEPTH)) ? r_cap_cnt[SW-1:0] : SW'(RING_DEPTH);
    assign dis_span = (r_dis_cnt < 32'(RING_DEPTH)) ? r_dis_cnt[SW-1:0] : SW'(RING_DEPTH);

    // compare of the entries read last cycle
    assign cap_hit = (r_qframe == ftshr_pkg::LATEST_FRAME) || (r_cap_rd.frame == r_qframe);
    assign dis_hit = (r_dis_rd.frame == r_qframe);
    assign cap_done_n = r_cap_done || cap_hit || (r_cap_left == SW'(1));
    assign dis_done_n = r_dis_done || dis_hit || (r_dis_left == SW'(1));

    // capture ring memory
    always_ff @(posedge i_clk) begin
        if (cap_wr) begin
            cap_mem[r_cap_ptr] <= cap_wdata;
        end
        if (r_state == ST_READ) begin
            r_cap_rd <= cap_mem[r_cap_addr];
        end
    end

    // discard ring memory
    always_ff @(posedge i_clk) begin
        if (dis_wr) begin
            dis_mem[r_dis_ptr] <= dis_wdata;
        end
        if (r_state == ST_READ) begin
            r_dis_rd <= dis_mem[r_dis_addr];
        end
    end

    // control, counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cap_cnt  <= '0;
            r_dis_cnt  <= '0;
            r_mdis_cnt <= '0;
            r_cap_ptr  <= '0;
            r_dis_ptr  <= '0;
            r_cap_done <= 1'b1;
            r_dis_done <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_FINISH);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (kind)
                            ftshr_pkg::KIND_CAPTURE: begin
                                r_cap_cnt <= r_cap_cnt + 32'd1;
                                r_cap_ptr <= (r_cap_ptr == LAST_SLOT) ? '0 : r_cap_ptr + PW'(1);
                            end
                            ftshr_pkg::KIND_DISCARD: begin
                                r_dis_cnt <= r_dis_cnt + 32'd1;
                                r_dis_ptr <= (r_dis_ptr == LAST_SLOT) ? '0 : r_dis_ptr + PW'(1);
                                if (i_discard_mask != 8'd0) begin
                                    r_mdis_cnt <= r_mdis_cnt + 32'd1;
                                end
                            end
                            ftshr_pkg::KIND_CLEAR: begin
                                r_cap_cnt  <= '0;
                                r_dis_cnt  <= '0;
                                r_mdis_cnt <= '0;
                                r_cap_ptr  <= '0;
                                r_dis_ptr  <= '0;
                            end
                            ftshr_pkg::KIND_QUERY: begin
                                r_qframe   <= i_frame_number;
                                r_found    <= 1'b0;
                                r_match    <= '0;
                                r_dhit     <= 1'b0;
                                r_dmask    <= '0;
                                r_cap_left <= cap_span;
                                r_dis_left <= dis_span;
                                r_cap_done <= (cap_span == '0);
                                r_dis_done <= (dis_span == '0);
                                r_cap_addr <= (r_cap_ptr == '0) ? LAST_SLOT : r_cap_ptr - PW'(1);
                                r_dis_addr <= (r_dis_ptr == '0) ? LAST_SLOT : r_dis_ptr - PW'(1);
                                r_state    <= ST_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    // capture ring step
                    if (!r_cap_done) begin
                        if (cap_hit) begin
                            r_found <= 1'b1;
                            r_match <= r_cap_rd;
                        end
                        r_cap_left <= r_cap_left - SW'(1);
                        r_cap_addr <= (r_cap_addr == '0) ? LAST_SLOT : r_cap_addr - PW'(1);
                    end
                    // discard ring step
                    if (!r_dis_done) begin
                        if (dis_hit) begin
                            r_dhit  <= 1'b1;
                            r_dmask <= r_dis_rd.mask;
                        end
                        r_dis_left <= r_dis_left - SW'(1);
                        r_dis_addr <= (r_dis_addr == '0) ? LAST_SLOT : r_dis_addr - PW'(1);
                    end
                    r_cap_done <= cap_done_n;
                    r_dis_done <= dis_done_n;
                    r_state    <= (cap_done_n && dis_done_n) ? ST_FINISH : ST_READ;
                end
                ST_FINISH: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign busy                   = (r_state != ST_IDLE);
    assign o_valid                = r_valid;
    assign o_requested_frame      = r_qframe;
    assign o_found                = r_found;
    assign o_match_frame          = r_match.frame;
    assign o_match_clock          = r_match.clock;
    assign o_match_sequence       = r_match.sequence_cnt;
    assign o_capture_total        = r_cap_cnt;
    assign o_discard_total        = r_dis_cnt;
    assign o_masked_discard_total = r_mdis_cnt;
    assign o_discard_hit          = r_dhit;
    assign o_discard_hit_mask     = r_dmask;

endmodule

// ===== sv/ftshr_checker.sv =====
`include "frame_timestamp_history_ring_top_assert.svh"

module ftshr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        o_found,
    input logic [15:0] o_match_frame,
    input logic [31:0] o_match_clock,
    input logic [31:0] o_match_sequence
);

    logic query_req;
    logic other_req;

    assign query_req = start && !busy && (i_kind == ftshr_pkg::KIND_QUERY);
    assign other_req = start && !busy && (i_kind != ftshr_pkg::KIND_QUERY);

    // a query request always starts a search
    `FTSHR_ASSERT_NEXT(a_query_busy, query_req, busy, "query did not raise busy")

    // events and clears complete at once and give no result
    `FTSHR_ASSERT_NEXT(a_event_quiet, other_req, !busy && !o_valid, "event request gave result")

    // a result comes with the block free again
    `FTSHR_ASSERT_NOW(a_result_idle, o_valid, !busy, "result while busy")

    // single-cycle result strobe
    `FTSHR_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result repeated")

    // no capture match gives zero sample fields
    `FTSHR_ASSERT_NOW(a_miss_zero, o_valid && !o_found,
        o_match_frame == 16'd0 && o_match_clock == 32'd0 && o_match_sequence == 32'd0,
        "missed query with nonzero sample")

endmodule

bind frame_timestamp_history_ring_top ftshr_checker u_ftshr_checker (.*);
